/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Every check is sampled on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/pcbp_pkg.sv */
package pcbp_pkg;

  // Largest target that the table can hold.
  localparam int MAX_N = 127;

  // Table depth and the width of a table index or a total.
  localparam int TBL_DEPTH = MAX_N + 1;
  localparam int N_W = $clog2(TBL_DEPTH);

  // Widths of the request fields and of a count.
  localparam int IN_W = 8;
  localparam int CNT_W = 32;

  // Largest target, at the width of a request field.
  localparam logic [IN_W-1:0] MAX_N_IN = IN_W'(MAX_N);

endpackage

/* rtl/pcbp_ram.sv */
module pcbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and two registered read ports; a read at the address
  // written at the same edge returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/partition_count_bounded_parts.sv */
// Operation: with k' = min(k, n) >= 1, a request runs n + 1 table clear writes, then one
// read-modify-write per update step, then a drain step and a finish step that presents the result.
// Negative k or n, or k' = 0, skips the table and goes straight to the finish state.
// Requests: one at a time; in_stall_o stays high until the sequencer is back in idle.
// Reset: rst_ni is asynchronous and active low; the table needs no clearing after reset.
module partition_count_bounded_parts
  import pcbp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  max_part_i,
  input  logic signed [IN_W-1:0]  target_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CNT_W-1:0]        count_o
);

`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [N_W-1:0]   n_q, n_d;
  logic [N_W-1:0]   k_q, k_d;
  logic [N_W-1:0]   j_q, j_d;
  logic [N_W-1:0]   m_q, m_d;
  logic [CNT_W-1:0] result_q, result_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Pipeline stage between the table read and the write back.
  logic             p1_valid_q;
  logic [N_W-1:0]   p1_addr_a_q;
  logic [N_W-1:0]   p1_addr_b_q;

  // Copy of the write that took place at the edge the reads were sampled.
  logic             fwd_valid_q;
  logic [N_W-1:0]   fwd_addr_q;
  logic [CNT_W-1:0] fwd_data_q;

  logic             ram_we;
  logic [N_W-1:0]   ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [N_W-1:0]   ram_raddr_a;
  logic [N_W-1:0]   ram_raddr_b;
  logic [CNT_W-1:0] ram_rdata_a;
  logic [CNT_W-1:0] ram_rdata_b;
  logic [CNT_W-1:0] opnd_a;
  logic [CNT_W-1:0] opnd_b;
  logic [CNT_W-1:0] sum;

  logic             in_xfer;
  logic             out_free;
  logic             req_zero;
  logic [IN_W-1:0]  k_clamp;

  pcbp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TBL_DEPTH)
  ) u_ways_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Handshakes.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

  // Request decode: the part size is clamped to the target.
  assign req_zero = max_part_i[IN_W-1] || target_i[IN_W-1] ||
                    (IN_W'(target_i) > MAX_N_IN);
  assign k_clamp  = (max_part_i > target_i) ? IN_W'(target_i) : IN_W'(max_part_i);

  // Read both summands of the current step.
  assign ram_raddr_a = m_q;
  assign ram_raddr_b = m_q - j_q;

  // Forward the write that the registered reads could not see yet.
  assign opnd_a = (fwd_valid_q && fwd_addr_q == p1_addr_a_q) ? fwd_data_q : ram_rdata_a;
  assign opnd_b = (fwd_valid_q && fwd_addr_q == p1_addr_b_q) ? fwd_data_q : ram_rdata_b;
  assign sum    = opnd_a + opnd_b;

  // Table writes: the clear sweep, then the sums of the update steps.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = m_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = m_q;
      ram_wdata = (m_q == '0) ? CNT_W'(1) : '0;
    end else if (p1_valid_q) begin
      ram_we    = 1'b1;
      ram_waddr = p1_addr_a_q;
      ram_wdata = sum;
    end
  end

  // Sequencer over the clear sweep and the nested update loops.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    k_d         = k_q;
    j_d         = j_q;
    m_d         = m_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          n_d = target_i[N_W-1:0];
          k_d = k_clamp[N_W-1:0];
          j_d = N_W'(1);
          m_d = '0;
          if (req_zero) begin
            result_d = '0;
            state_d  = ST_FINISH;
          end else if (k_clamp == '0) begin
            result_d = (target_i == '0) ? CNT_W'(1) : '0;
            state_d  = ST_FINISH;
          end else begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (m_q == n_q) begin
          m_d     = N_W'(1);
          state_d = ST_UPDATE;
        end else begin
          m_d = m_q + N_W'(1);
        end
      end
      ST_UPDATE: begin
        if (m_q == n_q) begin
          if (j_q == k_q) begin
            state_d = ST_DRAIN;
          end else begin
            j_d = j_q + N_W'(1);
            m_d = j_q + N_W'(1);
          end
        end else begin
          m_d = m_q + N_W'(1);
        end
      end
      ST_DRAIN: begin
        // The last sum is the entry for the target itself.
        result_d = sum;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          count_d     = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      p1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      p1_valid_q  <= (state_q == ST_UPDATE);
      fwd_valid_q <= ram_we;
    end
  end

  // Payload and loop registers.
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    k_q         <= k_d;
    j_q         <= j_d;
    m_q         <= m_d;
    result_q    <= result_d;
    count_q     <= count_d;
    p1_addr_a_q <= ram_raddr_a;
    p1_addr_b_q <= ram_raddr_b;
    fwd_addr_q  <= ram_waddr;
    fwd_data_q  <= ram_wdata;
  end

  `ASSERT_PROP(a_p1_in_update, p1_valid_q |-> (state_q == ST_UPDATE || state_q == ST_DRAIN), "update write outside the update loop")
  `ASSERT_NEVER(a_step_range, state_q == ST_UPDATE && (m_q < j_q || m_q > n_q || j_q > k_q), "update step index out of range")
  `ASSERT_PROP(a_accept_busy, in_xfer |=> state_q != ST_IDLE, "request accepted but sequencer stayed idle")
  `ASSERT_PROP(a_finish_out, (state_q == ST_FINISH && out_free) |=> (state_q == ST_IDLE && out_valid_q), "finished result not presented")

endmodule
